// ===== src/bpdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bpdq_pkg
// Shared constants and types for the bounded priority deque bank: bank size,
// queue depth, identifier width, status codes and the entry store request.
// ----------------------------------------------------------------------------
package bpdq_pkg;

   localparam int NUM_QUEUES  = 32;
   localparam int QUEUE_DEPTH = 8;
   localparam int ID_WIDTH    = 16;

   localparam int QIDX_W   = 5;
   localparam int CAP_W    = 4;
   localparam int CNT_OUT_W = 4;

   localparam int QSEL_W  = $clog2(NUM_QUEUES);
   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W  = QSEL_W + PTR_W;
   localparam int WORD_W  = ID_WIDTH + 1;
   localparam int STORE_DEPTH = NUM_QUEUES * QUEUE_DEPTH;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(5);

   localparam logic OP_ENQ = 1'b0;
   localparam logic OP_DEQ = 1'b1;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [WORD_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } store_req_type;

endpackage

// ===== src/bpdq_store.sv =====
// ----------------------------------------------------------------------------
// bpdq_store
// Entry store: one word of {urgent, id} per slot, one write and one read port,
// registered read data.
// ----------------------------------------------------------------------------
module bpdq_store
   import bpdq_pkg::*;
(
   input  logic                clock,
   input  store_req_type       store_req,
   output logic [WORD_W-1:0]   rd_data
);

   logic [WORD_W-1:0] mem [STORE_DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         mem[store_req.wr_addr] <= store_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (store_req.rd_en) begin
         rd_data_ff <= mem[store_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/bpdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpdq_ctrl
// Input register, per-queue head pointers and counts, capacity register and
// result register. Decides each operation combinationally and drives the store.
// ----------------------------------------------------------------------------
module bpdq_ctrl
   import bpdq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 req_opcode,
   input  logic [QIDX_W-1:0]    req_queue_index,
   input  logic                 req_urgent_flag,
   input  logic [ID_WIDTH-1:0]  req_entry_id,
   input  logic                 csr_wr_en,
   input  logic [CAP_W-1:0]     csr_wr_data,
   output store_req_type        store_req,
   output logic                 rsp_strobe,
   output status_type           rsp_status,
   output logic                 rsp_pop,
   output logic [CNT_OUT_W-1:0] rsp_queue_count
);

   logic                 vld_ff;
   logic                 op_ff;
   logic [QSEL_W-1:0]    q_ff;
   logic                 urg_ff;
   logic [ID_WIDTH-1:0]  id_ff;
   logic [CAP_W-1:0]     cap_ff;

   logic [PTR_W-1:0]     head_ff [NUM_QUEUES];
   logic [CNT_W-1:0]     cnt_ff  [NUM_QUEUES];

   logic                 strobe_ff;
   status_type           status_ff;
   logic                 pop_ff;
   logic [CNT_W-1:0]     count_ff;

   logic [PTR_W-1:0]     cur_head;
   logic [CNT_W-1:0]     cur_cnt;
   logic [CNT_W-1:0]     limit;
   logic [PTR_W-1:0]     head_in;
   logic [CNT_W-1:0]     cnt_in;
   status_type           status_in;
   logic                 pop_in;
   store_req_type        req_in;

   assign cur_head = head_ff[q_ff];
   assign cur_cnt  = cnt_ff[q_ff];

   always_comb begin
      if (cap_ff > CAP_W'(QUEUE_DEPTH)) begin
         limit = CNT_W'(QUEUE_DEPTH);
      end else begin
         limit = CNT_W'(cap_ff);
      end
   end

   always_comb begin
      head_in         = cur_head;
      cnt_in          = cur_cnt;
      status_in       = ST_DONE;
      pop_in          = 1'b0;
      req_in.wr_en    = 1'b0;
      req_in.wr_addr  = {q_ff, cur_head};
      req_in.wr_data  = {urg_ff, id_ff};
      req_in.rd_en    = 1'b0;
      req_in.rd_addr  = {q_ff, cur_head};
      if (op_ff == OP_ENQ) begin
         if (cur_cnt >= limit) begin
            status_in = ST_FULL;
         end else begin
            req_in.wr_en = vld_ff;
            if (urg_ff) begin
               head_in        = cur_head - PTR_W'(1);
               req_in.wr_addr = {q_ff, head_in};
            end else begin
               req_in.wr_addr = {q_ff, cur_head + cur_cnt[PTR_W-1:0]};
            end
            cnt_in = cur_cnt + CNT_W'(1);
         end
      end else begin
         if (cur_cnt == '0) begin
            status_in = ST_EMPTY;
         end else begin
            req_in.rd_en = vld_ff;
            pop_in       = 1'b1;
            head_in      = cur_head + PTR_W'(1);
            cnt_in       = cur_cnt - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= 1'b0;
         strobe_ff <= 1'b0;
         cap_ff    <= CAP_RESET;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            head_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
      end else begin
         vld_ff    <= accept;
         strobe_ff <= vld_ff;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         if (vld_ff) begin
            head_ff[q_ff] <= head_in;
            cnt_ff[q_ff]  <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_opcode;
         q_ff   <= req_queue_index[QSEL_W-1:0];
         urg_ff <= req_urgent_flag;
         id_ff  <= req_entry_id;
      end
      if (vld_ff) begin
         status_ff <= status_in;
         pop_ff    <= pop_in;
         count_ff  <= cnt_in;
      end
   end

   assign store_req       = req_in;
   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_pop         = pop_ff;
   assign rsp_queue_count = CNT_OUT_W'(count_ff);

`ifndef ASSERT_OFF
   a_beat_follows: assert property (@(posedge clock) disable iff (reset)
      vld_ff |=> strobe_ff)
      else $error("result beat missing");

   a_store_one_port: assert property (@(posedge clock) disable iff (reset)
      $onehot0({store_req.wr_en, store_req.rd_en}))
      else $error("store read and write in one beat");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff |-> cur_cnt <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (vld_ff && op_ff == OP_DEQ && cur_cnt == '0) |=> rsp_status == ST_EMPTY && !rsp_pop)
      else $error("empty dequeue not reported");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (vld_ff && op_ff == OP_ENQ && cur_cnt >= limit) |=> rsp_status == ST_FULL)
      else $error("full enqueue not rejected");
`endif

endmodule

// ===== src/bounded_priority_deque_bank.sv =====
// ----------------------------------------------------------------------------
// bounded_priority_deque_bank
// Bank of bounded queues with urgent insert at the head, regular append at
// the tail, dequeue from the head and a shared capacity limit.
//
//   channel   ports                      handshake
//   request   req_*                      start high, busy low
//   result    rsp_*                      rsp_strobe, one cycle, no stall
//   config    csr_wr_en, csr_wr_data     csr_wr_en, written at once
//
// One item per cycle; each request passes through the input register, then the
// result register and store read register before its result appears.
// Queue state sits in flip-flops and the entries in one single-port-write,
// single-port-read store; a beat reads and updates the state of one queue.
// Synchronous reset clears head pointers and counts and sets the limit to 5;
// busy is high only during reset. Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module bounded_priority_deque_bank
   import bpdq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_opcode,
   input  logic [QIDX_W-1:0]    req_queue_index,
   input  logic                 req_urgent_flag,
   input  logic [ID_WIDTH-1:0]  req_entry_id,
   output logic                 rsp_strobe,
   output logic [1:0]           rsp_status,
   output logic [ID_WIDTH-1:0]  rsp_popped_id,
   output logic                 rsp_popped_urgent,
   output logic [CNT_OUT_W-1:0] rsp_queue_count,
   input  logic                 csr_wr_en,
   input  logic [CAP_W-1:0]     csr_wr_data
);

   store_req_type     store_req;
   logic [WORD_W-1:0] rd_data;
   status_type        status;
   logic              pop;
   logic              accept;

   assign busy   = reset;
   assign accept = start & ~busy;

   bpdq_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .req_opcode      (req_opcode),
      .req_queue_index (req_queue_index),
      .req_urgent_flag (req_urgent_flag),
      .req_entry_id    (req_entry_id),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .store_req       (store_req),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (status),
      .rsp_pop         (pop),
      .rsp_queue_count (rsp_queue_count)
   );

   bpdq_store u_store (
      .clock     (clock),
      .store_req (store_req),
      .rd_data   (rd_data)
   );

   assign rsp_status        = status;
   assign rsp_popped_id     = rd_data[ID_WIDTH-1:0] & {ID_WIDTH{pop}};
   assign rsp_popped_urgent = rd_data[ID_WIDTH] & pop;

endmodule

// ===== tb/sv/bounded_priority_deque_bank_tb.sv =====
// ----------------------------------------------------------------------------
// bounded_priority_deque_bank_tb
// Drives enqueue and dequeue beats into the deque bank and checks every result
// beat against the table entry for checked directed beats, else against a
// cycle-free model of the queues kept inside the bench. A short table of
// directed beats comes first, then random traffic in several phases, each
// under its own capacity limit, with random request idle cycles in all but one.
// ----------------------------------------------------------------------------
module bounded_priority_deque_bank_tb;
   import bpdq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      status_type             status;
      logic [ID_WIDTH-1:0]    id;
      logic                   urg;
      logic [CNT_OUT_W-1:0]   count;
   } deque_result_type;

   typedef enum logic {ROW_ITEM, ROW_LIMIT} row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic                   op;
      logic [QIDX_W-1:0]      q;
      logic                   urg;
      logic [ID_WIDTH-1:0]    id;
      logic                   chk;
      deque_result_type       want;
   } stim_row_type;

   localparam deque_result_type NO_RESULT = '{ST_DONE, 16'h0, 1'b0, 4'd0};
   localparam int NUM_PHASES = 7;
   localparam int PHASE_ITEMS = 64;

   // limit rows carry the new limit in the id field
   localparam stim_row_type DIR_ROWS [23] = '{
      '{ROW_ITEM,  OP_DEQ, 5'd0,  1'b1, 16'hFFFF, 1'b1, '{ST_EMPTY, 16'h0, 1'b0, 4'd0}},
      '{ROW_ITEM,  OP_ENQ, 5'd31, 1'b0, 16'h0000, 1'b1, '{ST_DONE, 16'h0, 1'b0, 4'd1}},
      '{ROW_ITEM,  OP_ENQ, 5'd31, 1'b0, 16'hFFFF, 1'b1, '{ST_DONE, 16'h0, 1'b0, 4'd2}},
      '{ROW_ITEM,  OP_ENQ, 5'd31, 1'b1, 16'h1234, 1'b1, '{ST_DONE, 16'h0, 1'b0, 4'd3}},
      '{ROW_ITEM,  OP_ENQ, 5'd31, 1'b1, 16'hABCD, 1'b1, '{ST_DONE, 16'h0, 1'b0, 4'd4}},
      '{ROW_ITEM,  OP_ENQ, 5'd31, 1'b0, 16'h5555, 1'b1, '{ST_DONE, 16'h0, 1'b0, 4'd5}},
      '{ROW_ITEM,  OP_ENQ, 5'd31, 1'b1, 16'hAAAA, 1'b1, '{ST_FULL, 16'h0, 1'b0, 4'd5}},
      '{ROW_ITEM,  OP_DEQ, 5'd31, 1'b0, 16'hFFFF, 1'b1, '{ST_DONE, 16'hABCD, 1'b1, 4'd4}},
      '{ROW_ITEM,  OP_DEQ, 5'd31, 1'b1, 16'h0000, 1'b0, NO_RESULT},
      '{ROW_ITEM,  OP_DEQ, 5'd31, 1'b0, 16'h8001, 1'b0, NO_RESULT},
      '{ROW_ITEM,  OP_DEQ, 5'd31, 1'b1, 16'h7FFE, 1'b0, NO_RESULT},
      '{ROW_ITEM,  OP_DEQ, 5'd31, 1'b0, 16'h0000, 1'b0, NO_RESULT},
      '{ROW_ITEM,  OP_DEQ, 5'd31, 1'b0, 16'h0000, 1'b1, '{ST_EMPTY, 16'h0, 1'b0, 4'd0}},
      '{ROW_LIMIT, OP_ENQ, 5'd0,  1'b0, 16'd0,    1'b0, NO_RESULT},
      '{ROW_ITEM,  OP_ENQ, 5'd7,  1'b0, 16'hFFFF, 1'b1, '{ST_FULL, 16'h0, 1'b0, 4'd0}},
      '{ROW_ITEM,  OP_ENQ, 5'd7,  1'b1, 16'h0001, 1'b1, '{ST_FULL, 16'h0, 1'b0, 4'd0}},
      '{ROW_ITEM,  OP_DEQ, 5'd7,  1'b1, 16'hFFFF, 1'b1, '{ST_EMPTY, 16'h0, 1'b0, 4'd0}},
      '{ROW_LIMIT, OP_ENQ, 5'd0,  1'b0, 16'd15,   1'b0, NO_RESULT},
      '{ROW_ITEM,  OP_ENQ, 5'd16, 1'b1, 16'h8000, 1'b0, NO_RESULT},
      '{ROW_ITEM,  OP_ENQ, 5'd16, 1'b0, 16'h7FFF, 1'b0, NO_RESULT},
      '{ROW_ITEM,  OP_DEQ, 5'd16, 1'b1, 16'hFFFF, 1'b0, NO_RESULT},
      '{ROW_ITEM,  OP_DEQ, 5'd16, 1'b0, 16'h0000, 1'b0, NO_RESULT},
      '{ROW_ITEM,  OP_DEQ, 5'd16, 1'b0, 16'h0000, 1'b1, '{ST_EMPTY, 16'h0, 1'b0, 4'd0}}
   };

   localparam int PHASE_LIMITS [NUM_PHASES] = '{8, 1, 15, 0, 3, 8, 0};

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic                 req_opcode = OP_ENQ;
   logic [QIDX_W-1:0]    req_queue_index = '0;
   logic                 req_urgent_flag = 1'b0;
   logic [ID_WIDTH-1:0]  req_entry_id = '0;
   logic                 rsp_strobe;
   logic [1:0]           rsp_status;
   logic [ID_WIDTH-1:0]  rsp_popped_id;
   logic                 rsp_popped_urgent;
   logic [CNT_OUT_W-1:0] rsp_queue_count;
   logic                 csr_wr_en = 1'b0;
   logic [CAP_W-1:0]     csr_wr_data = '0;

   logic [WORD_W-1:0]    entry_mem [STORE_DEPTH];
   int                   head_ptr [NUM_QUEUES];
   int                   q_count [NUM_QUEUES];
   int                   cfg_limit;

   deque_result_type     pending_results [$];
   int                   errors = 0;
   int                   n_beats = 0;
   int                   n_full = 0;
   int                   n_empty = 0;
   int                   n_pops = 0;
   int                   n_checked = 0;
   bit                   gaps_on = 1'b1;

   bounded_priority_deque_bank dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_queue_index   (req_queue_index),
      .req_urgent_flag   (req_urgent_flag),
      .req_entry_id      (req_entry_id),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_popped_id     (rsp_popped_id),
      .rsp_popped_urgent (rsp_popped_urgent),
      .rsp_queue_count   (rsp_queue_count),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic deque_result_type apply_deque_op(logic op, logic [QIDX_W-1:0] q,
                                                       logic urg, logic [ID_WIDTH-1:0] id);
      deque_result_type r;
      int lim;
      int hd;
      int cnt;
      int slot;
      lim = (cfg_limit > QUEUE_DEPTH) ? QUEUE_DEPTH : cfg_limit;
      hd = head_ptr[q];
      cnt = q_count[q];
      r = NO_RESULT;
      if (op == OP_ENQ) begin
         if (cnt >= lim) begin
            r.status = ST_FULL;
         end else begin
            if (urg) begin
               hd = (hd + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
               slot = hd;
            end else begin
               slot = (hd + cnt) % QUEUE_DEPTH;
            end
            entry_mem[q * QUEUE_DEPTH + slot] = {urg, id};
            cnt++;
         end
      end else if (cnt == 0) begin
         r.status = ST_EMPTY;
      end else begin
         {r.urg, r.id} = entry_mem[q * QUEUE_DEPTH + hd];
         hd = (hd + 1) % QUEUE_DEPTH;
         cnt--;
      end
      head_ptr[q] = hd;
      q_count[q] = cnt;
      r.count = CNT_OUT_W'(cnt);
      return r;
   endfunction

   task automatic send_beat(input logic op, input logic [QIDX_W-1:0] q, input logic urg,
                            input logic [ID_WIDTH-1:0] id, input logic chk,
                            input deque_result_type want);
      deque_result_type r;
      bit took;
      while (gaps_on && $urandom_range(99) < 19) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_opcode <= op;
      req_queue_index <= q;
      req_urgent_flag <= urg;
      req_entry_id <= id;
      do begin
         @(negedge clock);
         took = !busy;
         @(posedge clock);
      end while (!took);
      r = apply_deque_op(op, q, urg, id);
      n_beats++;
      if (r.status == ST_FULL) n_full++;
      if (r.status == ST_EMPTY) n_empty++;
      if (op == OP_DEQ && r.status == ST_DONE) n_pops++;
      pending_results.insert(pending_results.size(), chk ? want : r);
   endtask

   task automatic set_limit(input logic [CAP_W-1:0] v);
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_limit = v;
   endtask

   always @(negedge clock) begin
      deque_result_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_results.size() == 0) begin
            $error("result beat with nothing expected");
            errors++;
         end else begin
            want = pending_results[0];
            pending_results.delete(0);
            n_checked++;
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               errors++;
            end
            if (rsp_popped_id !== want.id) begin
               $error("popped_id: expected %h, actual %h", want.id, rsp_popped_id);
               errors++;
            end
            if (rsp_popped_urgent !== want.urg) begin
               $error("popped_urgent: expected %b, actual %b", want.urg, rsp_popped_urgent);
               errors++;
            end
            if (rsp_queue_count !== want.count) begin
               $error("queue_count: expected %0d, actual %0d", want.count, rsp_queue_count);
               errors++;
            end
         end
      end
   end

   initial begin
      logic [QIDX_W-1:0] hot_q [3];
      logic [QIDX_W-1:0] q;
      logic op;
      bit fill;
      int lim;
      for (int i = 0; i < NUM_QUEUES; i++) begin
         head_ptr[i] = 0;
         q_count[i] = 0;
      end
      cfg_limit = CAP_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (DIR_ROWS[i]) begin
         if (DIR_ROWS[i].kind == ROW_LIMIT) begin
            set_limit(DIR_ROWS[i].id[CAP_W-1:0]);
         end else begin
            send_beat(DIR_ROWS[i].op, DIR_ROWS[i].q, DIR_ROWS[i].urg, DIR_ROWS[i].id,
                      DIR_ROWS[i].chk, DIR_ROWS[i].want);
         end
      end

      // hammer a few hot queues, swinging between filling and draining
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         lim = (ph == NUM_PHASES - 1) ? $urandom_range(7, 2) : PHASE_LIMITS[ph];
         set_limit(CAP_W'(lim));
         gaps_on = (ph != 2);
         foreach (hot_q[k]) hot_q[k] = QIDX_W'($urandom_range(NUM_QUEUES - 1));
         fill = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(9) == 0) fill = !fill;
            q = ($urandom_range(99) < 80) ? hot_q[$urandom_range(2)]
                                          : QIDX_W'($urandom_range(NUM_QUEUES - 1));
            op = ($urandom_range(99) < (fill ? 75 : 25)) ? OP_ENQ : OP_DEQ;
            send_beat(op, q, 1'($urandom_range(1)), ID_WIDTH'($urandom_range(16'hFFFF)),
                      1'b0, NO_RESULT);
         end
      end

      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      $display("%0d beats sent over %0d limit settings, %0d results checked", n_beats,
               NUM_PHASES + 2, n_checked);
      $display("%0d pops, %0d rejected as full, %0d dequeues on empty", n_pops, n_full,
               n_empty);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
